// ===== hdl/nfa_pkg.sv =====
// Shared types and codes for the next-fit descriptor slot allocator.
package nfa_pkg;

  // Operation codes carried on the request tuser.
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_GET   = 2'd2
  } func_e;

  // Result status codes carried on the result tuser.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_INVAL = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Slots below this index are reserved and never filled.
  localparam int unsigned FIRST_SLOT = 3;

  // One table entry; a zero handle marks the slot as empty.
  typedef struct packed {
    logic [31:0] flags;
    logic [31:0] handle;
  } slot_t;

endpackage

// ===== hdl/nfa_slot_ram.sv =====
// Slot table storage: one write port and one registered read port.
module nfa_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  nfa_pkg::slot_t   wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output nfa_pkg::slot_t   rdata_o
);
  import nfa_pkg::*;

  slot_t mem_q [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/next_fit_descriptor_slot_allocator.sv =====
// Top level of the next-fit descriptor slot allocator: sequencer, hint and result path.
//
// Requests arrive on the s_axis channel: tuser carries the operation (allocate, free or
// get) and tdata carries the slot index, the file handle and the flag word. Each request
// yields exactly one result on the m_axis channel: tuser carries the status and tdata the
// granted slot, the handle read and the flags read.
//
// After reset the block runs a clearing pass that writes every slot of the table to empty,
// one slot per cycle; s_axis_tready stays low meanwhile. The next-fit hint starts at
// slot 3.
//
// Free and invalid requests go from acceptance through the S_RESP state into the output
// register; get on a slot in the table passes through S_READ first because of the
// registered table read. Allocate walks the table through the single read port of the
// slot memory, one slot per cycle starting at the hint and wrapping to slot 3, until it
// finds an empty slot or has checked every usable one and answers with a full status.
// The block is ready again the cycle after the result is loaded, and one request is
// processed at a time.
//
// Results sit in an output register. A new request is taken while an earlier result still
// waits there; if the receiver stalls, the finished result of the new request waits in the
// sequencer until the output register is free, and no further request is accepted.
module next_fit_descriptor_slot_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: slot_index[9:0], file_handle[41:10], open_flags[73:42], zero pad.
  input  logic [79:0] s_axis_tdata,
  // From bit 0: func[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: granted_slot[9:0], read_handle[41:10], read_flags[73:42], zero pad.
  output logic [79:0] m_axis_tdata,
  // From bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser
);
  import nfa_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned HW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [HW-1:0] hint_q, hint_d;
  logic [AW-1:0] scan_addr_q, scan_addr_d;
  logic [HW-1:0] remain_q, remain_d;
  logic          chk_vld_q, chk_vld_d;
  logic          chk_last_q, chk_last_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [31:0]   handle_q, handle_d;
  logic [31:0]   flags_q, flags_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [9:0]    res_slot_q, res_slot_d;
  logic [31:0]   res_handle_q, res_handle_d;
  logic [31:0]   res_flags_q, res_flags_d;
  logic          m_tvalid_q, m_tvalid_d;
  logic [79:0]   m_tdata_q;
  logic [1:0]    m_tuser_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  slot_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  slot_t         ram_rdata;

  logic          accept;
  logic          out_load;
  func_e         in_func;
  logic [9:0]    in_idx;
  logic [31:0]   in_handle;
  logic [31:0]   in_flags;
  logic          idx_in_table;
  logic          idx_freeable;
  logic [AW-1:0] scan_start;
  logic [AW-1:0] scan_next;

  // Request field unpacking.
  assign in_func   = func_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[9:0];
  assign in_handle = s_axis_tdata[41:10];
  assign in_flags  = s_axis_tdata[73:42];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign idx_in_table = ({1'b0, in_idx} < 11'(SLOTS));
  assign idx_freeable = idx_in_table && (in_idx >= 10'(FIRST_SLOT));

  // The search begins at the hint; a hint past the top means the first pass is empty.
  assign scan_start = (hint_q >= HW'(SLOTS)) ? AW'(FIRST_SLOT) : hint_q[AW-1:0];
  // The scan address step wraps from the top slot back to the first usable one.
  assign scan_next  = (scan_addr_q == AW'(SLOTS - 1)) ? AW'(FIRST_SLOT)
                                                      : scan_addr_q + AW'(1);

  // The result register frees up when it is empty or being taken this cycle.
  assign out_load = (state_q == S_RESP) && (!m_tvalid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    scan_addr_d  = scan_addr_q;
    remain_d     = remain_q;
    chk_vld_d    = 1'b0;
    chk_last_d   = 1'b0;
    chk_addr_d   = scan_addr_q;
    handle_d     = handle_q;
    flags_d      = flags_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_flags_d  = res_flags_q;
    ram_we       = 1'b0;
    ram_waddr    = in_idx[AW-1:0];
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = scan_addr_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          handle_d     = in_handle;
          flags_d      = in_flags;
          res_status_d = STATUS_OK;
          res_slot_d   = '0;
          res_handle_d = '0;
          res_flags_d  = '0;
          state_d      = S_RESP;
          case (in_func)
            FUNC_ALLOC: begin
              if (in_handle == 32'd0) begin
                res_status_d = STATUS_INVAL;
              end else begin
                scan_addr_d = scan_start;
                remain_d    = HW'(SLOTS - FIRST_SLOT);
                state_d     = S_SCAN;
              end
            end
            FUNC_FREE: begin
              if (idx_freeable) begin
                ram_we = 1'b1;
                if ({1'b0, in_idx} < 11'(hint_q)) begin
                  hint_d = HW'(in_idx);
                end
              end
            end
            FUNC_GET: begin
              if (idx_in_table) begin
                ram_re    = 1'b1;
                ram_raddr = in_idx[AW-1:0];
                state_d   = S_READ;
              end
            end
            default: begin
              res_status_d = STATUS_INVAL;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one slot read per cycle while slots remain; its contents are checked in the following cycle.
        if (remain_q != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q;
          scan_addr_d = scan_next;
          remain_d    = remain_q - HW'(1);
          chk_vld_d   = 1'b1;
          chk_last_d  = (remain_q == HW'(1));
        end
        if (chk_vld_q) begin
          if (ram_rdata.handle == 32'd0) begin
            ram_we           = 1'b1;
            ram_waddr        = chk_addr_q;
            ram_wdata.handle = handle_q;
            ram_wdata.flags  = flags_q;
            hint_d           = HW'(chk_addr_q) + HW'(1);
            res_slot_d       = 10'(chk_addr_q);
            chk_vld_d        = 1'b0;
            state_d          = S_RESP;
          end else if (chk_last_q) begin
            res_status_d = STATUS_FULL;
            state_d      = S_RESP;
          end
        end
      end

      S_READ: begin
        if (ram_rdata.handle != 32'd0) begin
          res_handle_d = ram_rdata.handle;
          res_flags_d  = ram_rdata.flags;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_tvalid_d = out_load ? 1'b1 : (m_tvalid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      hint_q     <= HW'(FIRST_SLOT);
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
      remain_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      hint_q     <= hint_d;
      chk_vld_q  <= chk_vld_d;
      chk_last_q <= chk_last_d;
      remain_q   <= remain_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q  <= scan_addr_d;
    chk_addr_q   <= chk_addr_d;
    handle_q     <= handle_d;
    flags_q      <= flags_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_flags_q  <= res_flags_d;
    if (out_load) begin
      m_tdata_q <= {6'd0, res_flags_q, res_handle_q, res_slot_q};
      m_tuser_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  nfa_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hdl/nfa_checker.sv =====
// Port-level assertions for the next-fit descriptor slot allocator, bound to the top level.
module nfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import nfa_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Failed requests carry no slot, handle or flags.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_INVAL || m_axis_tuser == STATUS_FULL) |->
      m_axis_tdata == 80'd0)
    else $error("failed request returned data");

  // A granted slot is never reserved, and an allocate returns nothing read.
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:0] != 10'd0) |->
      m_axis_tdata[9:0] >= 10'(FIRST_SLOT) && m_axis_tuser == STATUS_OK &&
      m_axis_tdata[73:10] == 64'd0)
    else $error("bad granted slot");

  // Status is a defined code and the padding bits stay clear.
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3 && m_axis_tdata[79:74] == 6'd0)
    else $error("undefined status or nonzero padding");

endmodule

bind next_fit_descriptor_slot_allocator nfa_checker u_nfa_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the next-fit descriptor slot allocator.
`timescale 1ns / 1ps

// The testbench streams allocate, free and get requests into the block and checks every
// result against its own model of the slot table. The model keeps the handles, the
// flags and the next-fit hint, and it predicts one result for each accepted request.
// A short directed part comes first. It covers reserved and out-of-range slots, the
// zero handle, the unused operation code and the extreme field values. Random requests
// follow in three phases with different idling on both sides. The share of allocate
// requests changes from block to block, so the table fills up, runs full, wraps and
// drains again.
module tb_top;
  import nfa_pkg::*;

  localparam int unsigned SLOTS = 64;
  // Operation code that the block does not define. It must answer with an
  // invalid-argument status and leave the table alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles without any handshake on either side before the run is called hung.
  // This is far beyond the clearing pass, a full-table scan and the longest random stall.
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [1:0]  func;
    logic [9:0]  slot_index;
    logic [31:0] file_handle;
    logic [31:0] open_flags;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  granted_slot;
    logic [31:0] read_handle;
    logic [31:0] read_flags;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  next_fit_descriptor_slot_allocator #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The testbench's own copy of the slot table and of the next-fit hint.
  logic [31:0] model_handles [SLOTS];
  logic [31:0] model_flags [SLOTS];
  logic [10:0] model_hint;

  request_t pending_requests [$];
  result_t  predicted_results [$];

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 80;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      model_handles[i] = '0;
      model_flags[i] = '0;
    end
    model_hint = 11'(FIRST_SLOT);
  end

  // Applies one request to the model table and returns the result the block owes for it.
  function automatic result_t table_outcome(input request_t req);
    result_t res;
    int unsigned start;
    int unsigned found;
    bit placed;
    res = '{status: STATUS_OK, granted_slot: '0, read_handle: '0, read_flags: '0};
    placed = 1'b0;
    found = 0;
    if (req.func == FUNC_ALLOC) begin
      if (req.file_handle == '0) begin
        res.status = STATUS_INVAL;
      end else begin
        if (model_hint < FIRST_SLOT) model_hint = 11'(FIRST_SLOT);
        start = model_hint;
        // Next fit: from the hint to the top, then wrap around to the first usable slot.
        for (int unsigned s = start; s < SLOTS && !placed; s++) begin
          if (model_handles[s] == '0) begin
            placed = 1'b1;
            found = s;
          end
        end
        for (int unsigned s = FIRST_SLOT; s < start && !placed; s++) begin
          if (model_handles[s] == '0) begin
            placed = 1'b1;
            found = s;
          end
        end
        if (placed) begin
          model_handles[found] = req.file_handle;
          model_flags[found] = req.open_flags;
          model_hint = 11'(found + 1);
          res.granted_slot = 10'(found);
        end else begin
          res.status = STATUS_FULL;
        end
      end
    end else if (req.func == FUNC_FREE) begin
      // Reserved and out-of-range slots are ignored. Freeing an empty slot still pulls
      // the hint down to it.
      if (req.slot_index >= FIRST_SLOT && req.slot_index < SLOTS) begin
        model_handles[req.slot_index] = '0;
        model_flags[req.slot_index] = '0;
        if (req.slot_index < model_hint) model_hint = 11'(req.slot_index);
        if (model_hint < FIRST_SLOT) model_hint = 11'(FIRST_SLOT);
      end
    end else if (req.func == FUNC_GET) begin
      if (req.slot_index < SLOTS && model_handles[req.slot_index] != '0) begin
        res.read_handle = model_handles[req.slot_index];
        res.read_flags = model_flags[req.slot_index];
      end
    end else begin
      res.status = STATUS_INVAL;
    end
    return res;
  endfunction

  // Request driver. When a request is taken, the model is updated with the values that
  // were on the bus at that edge, and its result is queued.
  always @(posedge clk_i) begin
    request_t req;
    if (s_axis_tvalid && s_axis_tready) begin
      req.func = s_axis_tuser;
      req.slot_index = s_axis_tdata[9:0];
      req.file_handle = s_axis_tdata[41:10];
      req.open_flags = s_axis_tdata[73:42];
      predicted_results.push_back(table_outcome(req));
    end
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        s_axis_tuser <= req.func;
        s_axis_tdata <= {6'b0, req.open_flags, req.file_handle, req.slot_index};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor. Every result taken is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (predicted_results.size() == 0) begin
        $error("result with no request outstanding: tuser %0d tdata %h",
               m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        exp_res = predicted_results.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[9:0] !== exp_res.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d",
                 exp_res.granted_slot, m_axis_tdata[9:0]);
          error_count++;
        end
        if (m_axis_tdata[41:10] !== exp_res.read_handle) begin
          $error("read_handle: expected %h, got %h", exp_res.read_handle,
                 m_axis_tdata[41:10]);
          error_count++;
        end
        if (m_axis_tdata[73:42] !== exp_res.read_flags) begin
          $error("read_flags: expected %h, got %h", exp_res.read_flags,
                 m_axis_tdata[73:42]);
          error_count++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Counts cycles in which neither channel completes a handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic queue_request(input logic [1:0] func, input logic [9:0] idx,
                               input logic [31:0] handle, input logic [31:0] flags);
    pending_requests.push_back('{func: func, slot_index: idx, file_handle: handle,
                                 open_flags: flags});
  endtask

  // Mostly usable slots, with some reserved and some past the top of the table.
  function automatic logic [9:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return 10'($urandom_range(SLOTS - 1, FIRST_SLOT));
    if (roll < 88) return 10'($urandom_range(FIRST_SLOT - 1, 0));
    if (roll < 92) return 10'h3FF;
    return 10'($urandom_range(1023, SLOTS));
  endfunction

  // Handles: a few zero ones to test rejection, a few extremes, the rest random.
  function automatic logic [31:0] pick_handle();
    int unsigned roll;
    logic [31:0] handle;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 9) return 32'hFFFF_FFFF;
    if (roll < 12) return 32'd1;
    handle = $urandom();
    return (handle == '0) ? 32'd7 : handle;
  endfunction

  // A block of random requests in which allocate takes about alloc_pct percent. A high
  // share drives the table full; a low one lets frees empty it again.
  task automatic queue_mix(input int unsigned count, input int unsigned alloc_pct);
    int unsigned roll;
    logic [1:0] func;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) func = FUNC_UNUSED;
      else if (roll < alloc_pct) func = FUNC_ALLOC;
      else if (roll < alloc_pct + (100 - alloc_pct) / 2) func = FUNC_FREE;
      else func = FUNC_GET;
      queue_request(func, pick_index(), pick_handle(), $urandom());
    end
  endtask

  // Waits until the driver has nothing left and every predicted result has arrived.
  // Sampling on the falling edge keeps this clear of the driver's updates.
  task automatic drain();
    @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    // Directed part: reserved and out-of-range slots, zero handle, the unused code,
    // the extreme values, the hint moving back down after a free.
    queue_request(FUNC_GET, 10'd0, '0, '0);
    queue_request(FUNC_GET, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(FUNC_GET, 10'd10, '0, '0);
    queue_request(FUNC_ALLOC, 10'd5, '0, 32'hFFFF_FFFF);
    queue_request(FUNC_ALLOC, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(FUNC_ALLOC, 10'd0, 32'd1, 32'd0);
    queue_request(FUNC_ALLOC, 10'd0, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    queue_request(FUNC_GET, 10'd3, '0, '0);
    queue_request(FUNC_GET, 10'd4, '0, '0);
    queue_request(FUNC_GET, 10'd2, '0, '0);
    queue_request(FUNC_FREE, 10'd0, '0, '0);
    queue_request(FUNC_FREE, 10'd2, '0, '0);
    queue_request(FUNC_FREE, 10'(SLOTS), '0, '0);
    queue_request(FUNC_FREE, 10'h3FF, '0, '0);
    queue_request(FUNC_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(FUNC_FREE, 10'd3, '0, '0);
    queue_request(FUNC_GET, 10'd3, '0, '0);
    queue_request(FUNC_ALLOC, 10'd0, 32'h0000_1234, 32'h8000_0001);
    queue_request(FUNC_FREE, 10'd40, '0, '0);
    queue_request(FUNC_FREE, 10'(SLOTS - 1), '0, '0);
    queue_request(FUNC_ALLOC, 10'd0, 32'h8000_0000, 32'h0000_0001);
    queue_request(FUNC_GET, 10'(SLOTS - 1), '0, '0);
    queue_request(FUNC_GET, 10'd5, '0, '0);
    queue_request(FUNC_GET, 10'(SLOTS), '0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: light sender gaps, heavy receiver stalls.
    queue_mix(115, 85);
    queue_mix(115, 25);
    queue_mix(115, 60);
    queue_mix(115, 90);
    // The sender holds back here until every outstanding result has come back.
    drain();

    // Phase two: heavy sender gaps, light receiver stalls.
    send_idle_pct = 80;
    recv_idle_pct = 23;
    queue_mix(115, 90);
    queue_mix(115, 20);
    queue_mix(115, 70);
    queue_mix(115, 85);
    drain();

    // Phase three: both sides run flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mix(115, 95);
    queue_mix(115, 30);
    queue_mix(115, 85);
    queue_mix(115, 15);
    drain();

    // Any result showing up after the last expected one is flagged by the monitor.
    repeat (4 * SLOTS) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
